// ----- design/rli_pkg.sv -----
`default_nettype none
package rli_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned RANK_W = 7;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_INSERT  = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell; only set for a transaction that succeeds
  typedef struct packed {
    logic ins;
    logic rem;
    logic rep;
  } cell_op_t;

  // levels of the 4-input read-out tree
  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned lv;
    lv = ($clog2(n) + 1) / 2;
    if (lv < 1) begin
      lv = 1;
    end
    return lv;
  endfunction

endpackage
`default_nettype wire

// ----- design/rli_cell.sv -----
`default_nettype none
module rli_cell import rli_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire                clk,
  input  wire cell_op_t      op,
  input  wire [RANK_W-1:0]   rank,
  input  wire [WORD_W-1:0]   value,
  input  wire [WORD_W-1:0]   left_word,
  input  wire [WORD_W-1:0]   right_word,
  output logic [WORD_W-1:0]  word,
  output logic [WORD_W-1:0]  sel_word
);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              at_rank;
  logic              above;

  assign at_rank = (32'(rank) == IDX);
  assign above   = (32'(rank) <  IDX);

  always_comb begin
    word_nxt = word_r;
    if (op.ins) begin
      if (at_rank) begin
        word_nxt = value;
      end else if (above) begin
        word_nxt = left_word;
      end
    end else if (op.rem) begin
      if (at_rank || above) begin
        word_nxt = right_word;
      end
    end else if (op.rep && at_rank) begin
      word_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign sel_word = at_rank ? word_r : '0;

endmodule
`default_nettype wire

// ----- design/rli_or_tree.sv -----
`default_nettype none
module rli_or_tree import rli_pkg::*; #(
  parameter int unsigned N_IN = 64
) (
  input  wire                clk,
  input  wire [WORD_W-1:0]   leaf_in [N_IN],
  output logic [WORD_W-1:0]  root
);

  localparam int unsigned LEVELS = tree_levels(N_IN);
  localparam int unsigned N_PAD  = 4 ** LEVELS;
  localparam int unsigned NODES  = (N_PAD - 1) / 3;

  logic [WORD_W-1:0] leaf   [N_PAD];
  logic [WORD_W-1:0] node_r [NODES];
  logic [WORD_W-1:0] kid    [NODES][4];

  for (genvar k = 0; k < N_PAD; k++) begin : g_leaf
    if (k < N_IN) begin : g_used
      assign leaf[k] = leaf_in[k];
    end else begin : g_pad
      assign leaf[k] = '0;
    end
  end

  // 4-ary heap: node j has children 4j+1 .. 4j+4
  for (genvar j = 0; j < NODES; j++) begin : g_node
    for (genvar c = 0; c < 4; c++) begin : g_kid
      localparam int unsigned KI = 4 * j + 1 + c;
      if (KI < NODES) begin : g_inner
        assign kid[j][c] = node_r[KI];
      end else begin : g_edge
        assign kid[j][c] = leaf[KI - NODES];
      end
    end
    always_ff @(posedge clk) begin
      node_r[j] <= kid[j][0] | kid[j][1] | kid[j][2] | kid[j][3];
    end
  end

  assign root = node_r[0];

endmodule
`default_nettype wire

// ----- design/ranked_list_insert_remove.sv -----
`default_nettype none
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready   | tuser: command; tdata: rank, value
// out_    | out | out_tvalid/out_tready | tuser: status; tdata: result_value, count
//
// Insert, remove and replace update the cell row at the accept edge;
// the read-out OR tree over the cells sets the latency of the returned word.
// A new transaction is taken only after the previous result is delivered.
// rst_n clears the count and handshake state; cell contents stay undefined.
module ranked_list_insert_remove import rli_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [1:0]  in_tuser,   // [1:0] command
  input  wire  [39:0] in_tdata,   // [6:0] rank, [38:7] value, [39] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata   // [31:0] result_value, [38:32] count, [39] zero
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned LEVELS = tree_levels(DEPTH);
  localparam int unsigned LAT_W  = $clog2(LEVELS + 1);

  cmd_t              cmd;
  logic [RANK_W-1:0] rank;
  logic [WORD_W-1:0] value;
  logic              accept;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              busy_r;
  logic              pend_r;
  logic [LAT_W-1:0]  lat_r;
  status_t           stat_r, stat_nxt;
  logic              useval_r, useval_nxt;

  logic              out_vld_r;
  status_t           out_stat_r;
  logic [WORD_W-1:0] out_val_r;
  logic [CNT_W-1:0]  out_cnt_r;

  cell_op_t          op;
  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] sel_word  [DEPTH];
  logic [WORD_W-1:0] root;

  assign cmd    = cmd_t'(in_tuser);
  assign rank   = in_tdata[RANK_W-1:0];
  assign value  = in_tdata[RANK_W +: WORD_W];
  assign accept = in_tvalid && in_tready;

  always_comb begin
    stat_nxt   = ST_OK;
    useval_nxt = 1'b0;
    count_nxt  = count_r;
    op         = '0;
    if (cmd == CMD_INSERT) begin
      if (32'(rank) > 32'(count_r)) begin
        stat_nxt = ST_RANGE;
      end else if (32'(count_r) >= DEPTH) begin
        stat_nxt = ST_FULL;
      end else begin
        op.ins    = accept;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (32'(rank) >= 32'(count_r)) begin
      stat_nxt = ST_RANGE;
    end else begin
      useval_nxt = 1'b1;
      op.rep     = accept && (cmd == CMD_REPLACE);
      op.rem     = accept && (cmd == CMD_REMOVE);
      if (cmd == CMD_REMOVE) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lw;
    logic [WORD_W-1:0] rw;
    if (i == 0) begin : g_first
      assign lw = '0;
    end else begin : g_lmid
      assign lw = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rw = '0;
    end else begin : g_rmid
      assign rw = cell_word[i+1];
    end
    rli_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .op         (op),
      .rank       (rank),
      .value      (value),
      .left_word  (lw),
      .right_word (rw),
      .word       (cell_word[i]),
      .sel_word   (sel_word[i])
    );
  end

  rli_or_tree #(.N_IN(DEPTH)) u_tree (
    .clk     (clk),
    .leaf_in (sel_word),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      busy_r    <= 1'b0;
      pend_r    <= 1'b0;
      lat_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        busy_r  <= 1'b1;
        pend_r  <= 1'b1;
        lat_r   <= '0;
      end else if (pend_r) begin
        if (lat_r == LAT_W'(LEVELS - 1)) begin
          pend_r    <= 1'b0;
          out_vld_r <= 1'b1;
        end else begin
          lat_r <= lat_r + LAT_W'(1);
        end
      end
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
        busy_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r    <= stat_nxt;
      useval_r  <= useval_nxt;
      out_cnt_r <= count_nxt;
    end
    if (pend_r && (lat_r == LAT_W'(LEVELS - 1))) begin
      out_stat_r <= stat_r;
      out_val_r  <= useval_r ? root : '0;
    end
  end

  assign in_tready  = !busy_r;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {1'b0, COUNT_OUT_W'(out_cnt_r), out_val_r};

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction accepted while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("count above capacity");

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy_r && !pend_r)
    else $error("result shown without pending transaction");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (32'(count_r) == DEPTH) |=> 32'(count_r) <= DEPTH - 1 || 32'(count_r) == DEPTH)
    else $error("count grew past full");
`endif

endmodule
`default_nettype wire
